### rtl/core/hbd_pkg.sv
package hbd_pkg;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_COUNT = 3'd1;
  localparam logic [2:0] CMD_BUILD = 3'd2;
  localparam logic [2:0] CMD_BIT   = 3'd3;
  localparam logic [2:0] CMD_END   = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MIDCODE = 2'd1;
  localparam logic [1:0] STAT_NOTREE  = 2'd2;
  localparam logic [1:0] STAT_PHASE   = 2'd3;

  localparam int unsigned CountW = 17;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0]        symbol;
    logic              symbol_valid;
    logic [1:0]        status;
    logic [CountW-1:0] decoded_count;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_HIST_RD, OP_HIST_WR, OP_SCAN_INIT, OP_SCAN_RD,
    OP_LEAF, OP_SCAN_NEXT, OP_PUSH_RD, OP_PUSH_PUT, OP_PUSH_MOVE,
    OP_POP_START, OP_POP_TAKE, OP_POP_RD, OP_POP_RDL, OP_POP_MOVE,
    OP_POP_FILL, OP_MERGE, OP_ROOT_RD, OP_ROOT, OP_DEC_RD, OP_DEC_NX,
    OP_DEC_STEP, OP_END
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CNT_WR, S_SCAN_RD, S_SCAN_CHK, S_SCAN_ADV, S_PUSH_TEST,
    S_PUSH_CMP, S_MERGE_TEST, S_POP_TOP, S_POP_TEST, S_POP_CMP,
    S_POP_LAST, S_POP_B, S_MERGE_NODE, S_ROOT_SET, S_DEC_NX, S_DEC_CHK,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e        op;
    logic       accept;
    logic [1:0] status;
    logic       second;
  } ctl_cmd_t;

  typedef struct packed {
    logic phase_dec;
    logic usable;
    logic limit_ok;
    logic hist_nz;
    logic scan_last;
    logic push_top;
    logic push_stop;
    logic pop_child;
    logic heap_ge2;
  } dp_stat_t;

endpackage

### rtl/core/hbd_ctrl.sv
module hbd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [2:0]       command_i,
  input  hbd_pkg::dp_stat_t stat_i,
  output hbd_pkg::ctl_cmd_t cmd_o,
  output logic             busy,
  output logic             done_o
);

  hbd_pkg::state_e state_q, state_d;
  logic ret_merge_q, ret_merge_d;
  logic pop_b_q, pop_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hbd_pkg::S_IDLE;
      ret_merge_q <= 1'b0;
      pop_b_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_merge_q <= ret_merge_d;
      pop_b_q     <= pop_b_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_merge_d = ret_merge_q;
    pop_b_d     = pop_b_q;
    cmd_o       = '{op: hbd_pkg::OP_NONE, accept: 1'b0,
                    status: hbd_pkg::STAT_OK, second: pop_b_q};
    busy        = 1'b1;
    done_o      = 1'b0;
    unique case (state_q)
      hbd_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = hbd_pkg::S_RESP;
          unique case (command_i)
            hbd_pkg::CMD_CLEAR: cmd_o.op = hbd_pkg::OP_CLEAR;
            hbd_pkg::CMD_COUNT: begin
              if (stat_i.phase_dec) cmd_o.status = hbd_pkg::STAT_PHASE;
              else begin
                cmd_o.op = hbd_pkg::OP_HIST_RD;
                state_d  = hbd_pkg::S_CNT_WR;
              end
            end
            hbd_pkg::CMD_BUILD: begin
              if (stat_i.phase_dec) cmd_o.status = hbd_pkg::STAT_PHASE;
              else begin
                cmd_o.op    = hbd_pkg::OP_SCAN_INIT;
                ret_merge_d = 1'b0;
                state_d     = hbd_pkg::S_SCAN_RD;
              end
            end
            hbd_pkg::CMD_BIT: begin
              if (!stat_i.phase_dec) cmd_o.status = hbd_pkg::STAT_PHASE;
              else if (!stat_i.usable) cmd_o.status = hbd_pkg::STAT_NOTREE;
              else if (stat_i.limit_ok) begin
                cmd_o.op = hbd_pkg::OP_DEC_RD;
                state_d  = hbd_pkg::S_DEC_NX;
              end
            end
            hbd_pkg::CMD_END: begin
              if (!stat_i.phase_dec) cmd_o.status = hbd_pkg::STAT_PHASE;
              else if (!stat_i.usable) cmd_o.status = hbd_pkg::STAT_NOTREE;
              else cmd_o.op = hbd_pkg::OP_END;
            end
            default: cmd_o.status = hbd_pkg::STAT_PHASE;
          endcase
        end
      end
      hbd_pkg::S_CNT_WR: begin
        cmd_o.op = hbd_pkg::OP_HIST_WR;
        state_d  = hbd_pkg::S_RESP;
      end
      hbd_pkg::S_SCAN_RD: begin
        cmd_o.op = hbd_pkg::OP_SCAN_RD;
        state_d  = hbd_pkg::S_SCAN_CHK;
      end
      hbd_pkg::S_SCAN_CHK: begin
        if (stat_i.hist_nz) begin
          cmd_o.op = hbd_pkg::OP_LEAF;
          state_d  = hbd_pkg::S_PUSH_TEST;
        end else begin
          state_d = hbd_pkg::S_SCAN_ADV;
        end
      end
      hbd_pkg::S_SCAN_ADV: begin
        cmd_o.op = hbd_pkg::OP_SCAN_NEXT;
        if (stat_i.scan_last) begin
          ret_merge_d = 1'b1;
          state_d     = hbd_pkg::S_MERGE_TEST;
        end else begin
          state_d = hbd_pkg::S_SCAN_RD;
        end
      end
      hbd_pkg::S_PUSH_TEST: begin
        if (stat_i.push_top) begin
          cmd_o.op = hbd_pkg::OP_PUSH_PUT;
          state_d  = ret_merge_q ? hbd_pkg::S_MERGE_TEST : hbd_pkg::S_SCAN_ADV;
        end else begin
          cmd_o.op = hbd_pkg::OP_PUSH_RD;
          state_d  = hbd_pkg::S_PUSH_CMP;
        end
      end
      hbd_pkg::S_PUSH_CMP: begin
        if (stat_i.push_stop) begin
          cmd_o.op = hbd_pkg::OP_PUSH_PUT;
          state_d  = ret_merge_q ? hbd_pkg::S_MERGE_TEST : hbd_pkg::S_SCAN_ADV;
        end else begin
          cmd_o.op = hbd_pkg::OP_PUSH_MOVE;
          state_d  = hbd_pkg::S_PUSH_TEST;
        end
      end
      hbd_pkg::S_MERGE_TEST: begin
        if (stat_i.heap_ge2) begin
          cmd_o.op = hbd_pkg::OP_POP_START;
          pop_b_d  = 1'b0;
          state_d  = hbd_pkg::S_POP_TOP;
        end else begin
          cmd_o.op = hbd_pkg::OP_ROOT_RD;
          state_d  = hbd_pkg::S_ROOT_SET;
        end
      end
      hbd_pkg::S_POP_TOP: begin
        cmd_o.op = hbd_pkg::OP_POP_TAKE;
        state_d  = hbd_pkg::S_POP_TEST;
      end
      hbd_pkg::S_POP_TEST: begin
        if (stat_i.pop_child) begin
          cmd_o.op = hbd_pkg::OP_POP_RD;
          state_d  = hbd_pkg::S_POP_CMP;
        end else begin
          cmd_o.op = hbd_pkg::OP_POP_RDL;
          state_d  = hbd_pkg::S_POP_LAST;
        end
      end
      hbd_pkg::S_POP_CMP: begin
        cmd_o.op = hbd_pkg::OP_POP_MOVE;
        state_d  = hbd_pkg::S_POP_TEST;
      end
      hbd_pkg::S_POP_LAST: begin
        cmd_o.op = hbd_pkg::OP_POP_FILL;
        state_d  = pop_b_q ? hbd_pkg::S_MERGE_NODE : hbd_pkg::S_POP_B;
      end
      hbd_pkg::S_POP_B: begin
        cmd_o.op = hbd_pkg::OP_POP_START;
        pop_b_d  = 1'b1;
        state_d  = hbd_pkg::S_POP_TOP;
      end
      hbd_pkg::S_MERGE_NODE: begin
        cmd_o.op = hbd_pkg::OP_MERGE;
        state_d  = hbd_pkg::S_PUSH_TEST;
      end
      hbd_pkg::S_ROOT_SET: begin
        cmd_o.op = hbd_pkg::OP_ROOT;
        state_d  = hbd_pkg::S_RESP;
      end
      hbd_pkg::S_DEC_NX: begin
        cmd_o.op = hbd_pkg::OP_DEC_NX;
        state_d  = hbd_pkg::S_DEC_CHK;
      end
      hbd_pkg::S_DEC_CHK: begin
        cmd_o.op = hbd_pkg::OP_DEC_STEP;
        state_d  = hbd_pkg::S_RESP;
      end
      hbd_pkg::S_RESP: begin
        done_o  = 1'b1;
        state_d = hbd_pkg::S_IDLE;
      end
      default: state_d = hbd_pkg::S_IDLE;
    endcase
  end

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back to back result strobe");
  a_accept_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> state_q == hbd_pkg::S_IDLE) else $error("accept outside idle");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> busy) else $error("transaction dropped");

endmodule

### rtl/core/hbd_datapath.sv
module hbd_datapath #(
  parameter int unsigned SYMBOLS    = 256,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbd_pkg::in_t      in_i,
  input  hbd_pkg::ctl_cmd_t cmd_i,
  input  logic              cfg_we_i,
  input  logic [16:0]       cfg_wdata_i,
  output hbd_pkg::dp_stat_t stat_o,
  output hbd_pkg::out_t     res_o
);

  localparam int unsigned NodeDepth = 2 * SYMBOLS - 1;
  localparam int unsigned NIW = $clog2(NodeDepth);
  localparam int unsigned SAW = $clog2(SYMBOLS);
  localparam int unsigned HIW = SAW + 1;
  localparam int unsigned CW  = hbd_pkg::CountW;

  typedef struct packed {
    logic [NIW-1:0]        left;
    logic [NIW-1:0]        right;
    logic [COUNT_BITS-1:0] freq;
    logic [7:0]            sym;
  } node_t;

  typedef struct packed {
    logic [NIW-1:0]        idx;
    logic [COUNT_BITS-1:0] freq;
  } heap_t;

  logic [COUNT_BITS-1:0] hist_mem [SYMBOLS];
  heap_t                 heap_mem [SYMBOLS];
  node_t                 node_mem [NodeDepth];

  logic [SYMBOLS-1:0]    hvld_q;
  logic [COUNT_BITS-1:0] hist_rd_q;
  heap_t                 heap_a_q, heap_b_q;
  node_t                 node_rd_q;

  logic [CW-1:0]  max_q, emitted_q;
  logic [NIW-1:0] nt_q, root_q, walk_q, nx_q;
  logic [HIW-1:0] fill_q, hi_q;
  logic [SAW-1:0] scan_q;
  logic           phase_q, end_q;
  logic [7:0]     val_q;
  heap_t          nd_q, pa_q, pb_q;
  hbd_pkg::out_t  res_q;

  logic [HIW-1:0] par_c, lch_c, rch_c, ha_addr_c;
  logic           heap_we_c, node_we_c, pick_r_c;
  logic [SAW-1:0] heap_wa_c, hist_ra_c;
  heap_t          heap_wd_c, pick_c;
  logic [NIW-1:0] node_ra_c, nx_c, walk_safe_c;
  node_t          node_wd_c;
  logic [COUNT_BITS-1:0] hcnt_c;
  logic [COUNT_BITS:0]   sum_c;
  logic [CW-1:0]  limit_c;
  logic [NIW-1:0] nx_raw_c;
  logic           hist_inc_c;

  assign par_c  = hi_q >> 1;
  assign lch_c  = hi_q << 1;
  assign rch_c  = lch_c + HIW'(1);
  assign pick_r_c = (rch_c <= fill_q) && (heap_b_q.freq < heap_a_q.freq);
  assign pick_c = pick_r_c ? heap_b_q : heap_a_q;
  assign sum_c  = {1'b0, pa_q.freq} + {1'b0, pb_q.freq};
  assign hcnt_c = hvld_q[val_q[SAW-1:0]] ? hist_rd_q : '0;
  assign hist_inc_c = (val_q != 8'd0) && ({1'b0, val_q} < 9'(SYMBOLS)) && (hcnt_c != '1);
  assign limit_c = (max_q == '0) ? CW'(1) : max_q;
  assign walk_safe_c = (walk_q >= NIW'(NodeDepth)) ? '0 : walk_q;
  assign nx_raw_c = (val_q == 8'd0) ? node_rd_q.left : node_rd_q.right;
  assign nx_c = (nx_raw_c >= NIW'(NodeDepth)) ? '0 : nx_raw_c;

  always_comb begin
    ha_addr_c = HIW'(1);
    case (cmd_i.op)
      hbd_pkg::OP_PUSH_RD: ha_addr_c = par_c;
      hbd_pkg::OP_POP_RD:  ha_addr_c = lch_c;
      hbd_pkg::OP_POP_RDL: ha_addr_c = fill_q + HIW'(1);
      default:             ha_addr_c = HIW'(1);
    endcase
    heap_we_c = 1'b0;
    heap_wa_c = hi_q[SAW-1:0];
    heap_wd_c = heap_a_q;
    case (cmd_i.op)
      hbd_pkg::OP_PUSH_PUT: begin
        heap_we_c = 1'b1;
        heap_wd_c = nd_q;
      end
      hbd_pkg::OP_PUSH_MOVE, hbd_pkg::OP_POP_FILL: heap_we_c = 1'b1;
      hbd_pkg::OP_POP_MOVE: begin
        heap_we_c = 1'b1;
        heap_wd_c = pick_c;
      end
      default: heap_we_c = 1'b0;
    endcase
    hist_ra_c = (cmd_i.op == hbd_pkg::OP_HIST_RD) ? in_i.value[SAW-1:0] : scan_q;
    node_ra_c = (cmd_i.op == hbd_pkg::OP_DEC_NX) ? nx_c : walk_safe_c;
    node_we_c = 1'b0;
    node_wd_c = '{left: '0, right: '0, freq: hist_rd_q, sym: 8'(scan_q)};
    case (cmd_i.op)
      hbd_pkg::OP_LEAF: node_we_c = 1'b1;
      hbd_pkg::OP_MERGE: begin
        node_we_c = 1'b1;
        node_wd_c = '{left: pa_q.idx, right: pb_q.idx,
                      freq: sum_c[COUNT_BITS] ? '1 : sum_c[COUNT_BITS-1:0],
                      sym: 8'd0};
      end
      default: node_we_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    hist_rd_q <= hist_mem[hist_ra_c];
    if (cmd_i.op == hbd_pkg::OP_HIST_WR && hist_inc_c) begin
      hist_mem[val_q[SAW-1:0]] <= hcnt_c + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    heap_a_q <= heap_mem[ha_addr_c[SAW-1:0]];
    heap_b_q <= heap_mem[rch_c[SAW-1:0]];
    if (heap_we_c) begin
      heap_mem[heap_wa_c] <= heap_wd_c;
    end
  end

  always_ff @(posedge clk_i) begin
    node_rd_q <= node_mem[node_ra_c];
    if (node_we_c) begin
      node_mem[nt_q] <= node_wd_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= CW'(65536);
      hvld_q    <= '0;
      emitted_q <= '0;
      nt_q      <= '0;
      root_q    <= '0;
      walk_q    <= '0;
      fill_q    <= '0;
      phase_q   <= 1'b0;
      end_q     <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (cmd_i.accept && cmd_i.op != hbd_pkg::OP_END) end_q <= 1'b0;
      case (cmd_i.op)
        hbd_pkg::OP_CLEAR: begin
          hvld_q    <= '0;
          emitted_q <= '0;
          nt_q      <= '0;
          root_q    <= '0;
          walk_q    <= '0;
          fill_q    <= '0;
          phase_q   <= 1'b0;
        end
        hbd_pkg::OP_HIST_WR: begin
          if (hist_inc_c) begin
            hvld_q[val_q[SAW-1:0]] <= 1'b1;
          end
        end
        hbd_pkg::OP_LEAF, hbd_pkg::OP_MERGE: begin
          nt_q   <= nt_q + NIW'(1);
          fill_q <= fill_q + HIW'(1);
        end
        hbd_pkg::OP_POP_START: fill_q <= fill_q - HIW'(1);
        hbd_pkg::OP_ROOT: begin
          root_q    <= (fill_q != '0) ? heap_a_q.idx : '0;
          walk_q    <= (fill_q != '0) ? heap_a_q.idx : '0;
          emitted_q <= '0;
          phase_q   <= 1'b1;
        end
        hbd_pkg::OP_DEC_STEP: begin
          if (node_rd_q.sym != 8'd0) begin
            emitted_q <= emitted_q + CW'(1);
            walk_q    <= root_q;
          end else begin
            walk_q <= nx_q;
          end
        end
        hbd_pkg::OP_END: begin
          end_q     <= 1'b1;
          walk_q    <= root_q;
          emitted_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      val_q              <= in_i.value;
      res_q.symbol       <= '0;
      res_q.symbol_valid <= 1'b0;
      if (cmd_i.op == hbd_pkg::OP_END) begin
        res_q.status <= (walk_q != root_q) ? hbd_pkg::STAT_MIDCODE : hbd_pkg::STAT_OK;
      end else begin
        res_q.status <= cmd_i.status;
      end
    end
    case (cmd_i.op)
      hbd_pkg::OP_SCAN_INIT: scan_q <= SAW'(1);
      hbd_pkg::OP_SCAN_NEXT: scan_q <= scan_q + SAW'(1);
      hbd_pkg::OP_LEAF: begin
        nd_q <= '{idx: nt_q, freq: hist_rd_q};
        hi_q <= fill_q + HIW'(1);
      end
      hbd_pkg::OP_MERGE: begin
        nd_q <= '{idx: nt_q, freq: node_wd_c.freq};
        hi_q <= fill_q + HIW'(1);
      end
      hbd_pkg::OP_PUSH_MOVE: hi_q <= par_c;
      hbd_pkg::OP_POP_START: hi_q <= HIW'(1);
      hbd_pkg::OP_POP_TAKE: begin
        if (!cmd_i.second) pa_q <= heap_a_q;
        else pb_q <= heap_a_q;
      end
      hbd_pkg::OP_POP_MOVE:  hi_q <= pick_r_c ? rch_c : lch_c;
      hbd_pkg::OP_DEC_NX:    nx_q <= nx_c;
      hbd_pkg::OP_DEC_STEP: begin
        if (node_rd_q.sym != 8'd0) begin
          res_q.symbol       <= node_rd_q.sym;
          res_q.symbol_valid <= 1'b1;
        end
      end
      hbd_pkg::OP_END: begin
        res_q.decoded_count <= emitted_q;
      end
      default: ;
    endcase
  end

  // first pop result held in pa_q, second in pb_q while merging
  always_comb begin
    stat_o.phase_dec = phase_q;
    stat_o.usable    = nt_q >= NIW'(3);
    stat_o.limit_ok  = emitted_q < limit_c;
    stat_o.hist_nz   = hvld_q[scan_q] && (hist_rd_q != '0);
    stat_o.scan_last = scan_q == SAW'(SYMBOLS - 1);
    stat_o.push_top  = par_c == '0;
    stat_o.push_stop = heap_a_q.freq <= nd_q.freq;
    stat_o.pop_child = lch_c <= fill_q;
    stat_o.heap_ge2  = fill_q >= HIW'(2);
    res_o.symbol        = res_q.symbol;
    res_o.symbol_valid  = res_q.symbol_valid;
    res_o.status        = res_q.status;
    res_o.decoded_count = end_q ? res_q.decoded_count : emitted_q;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= HIW'(SYMBOLS - 1)) else $error("heap overfilled");
  a_merge_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == hbd_pkg::OP_MERGE |=> nt_q == $past(nt_q) + NIW'(1))
    else $error("node count not advanced");
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q < NIW'(NodeDepth)) else $error("walk beyond node table");

endmodule

### rtl/core/huffman_tree_build_and_decode_core.sv
// clear, wrong phase and limit hits go straight from accept to the result strobe; count byte
// reads then writes the histogram; decode bit reads the node, then its child, then steps; end of bits
// goes straight to the strobe; build tree scans each byte value, pushes a leaf per used one, then pops two and merges
// the core takes one transaction at a time, set by the heap and node memory sequencer
// result is a one cycle strobe on done_o; the receiver cannot stall
// reset clears the sequencer, tree and decode state and histogram valid bits; heap and node memories keep contents
module huffman_tree_build_and_decode_core #(
  parameter int unsigned SYMBOLS    = 256,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hbd_pkg::in_t  in_i,
  output logic          done_o,
  output hbd_pkg::out_t res_o,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_wdata_i
);

  hbd_pkg::ctl_cmd_t cmd;
  hbd_pkg::dp_stat_t stat;

  hbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (in_i.command),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy),
    .done_o    (done_o)
  );

  hbd_datapath #(
    .SYMBOLS    (SYMBOLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NODES = 511;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef enum bit {PH_COUNT, PH_DECODE} phase_e;

  class huff_scoreboard;
    bit [31:0]   hist[256];
    int unsigned heap[257];
    int unsigned lft[NODES];
    int unsigned rgt[NODES];
    bit [31:0]   frq[NODES];
    bit [7:0]    sy[NODES];
    int unsigned ntot, hfill, root, walk, emitted;
    bit [16:0]   max_sym = 17'd65536;
    phase_e      ph;
    hbd_pkg::out_t pending[$];
    int          errors;

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void clear_all();
      foreach (hist[i]) hist[i] = '0;
      foreach (heap[i]) heap[i] = 0;
      foreach (lft[i]) begin
        lft[i] = 0; rgt[i] = 0; frq[i] = '0; sy[i] = '0;
      end
      ntot = 0; hfill = 0; root = 0; walk = 0; emitted = 0;
      ph = PH_COUNT;
    endfunction

    function bit [31:0] freq_of(int unsigned idx);
      return idx < NODES ? frq[idx] : 32'd0;
    endfunction

    function void heap_push(int unsigned nd);
      int unsigned i, j;
      if (hfill >= 256) return;
      hfill++;
      i = hfill;
      while (i / 2 != 0) begin
        j = i / 2;
        if (freq_of(heap[j]) <= freq_of(nd)) break;
        heap[i] = heap[j];
        i = j;
      end
      heap[i] = nd;
    endfunction

    function int unsigned heap_pop();
      int unsigned top, i, l;
      if (hfill == 0) return 0;
      top = heap[1];
      hfill--;
      i = 1;
      while (i * 2 <= hfill) begin
        l = i * 2;
        if (l + 1 <= hfill && freq_of(heap[l + 1]) < freq_of(heap[l])) l++;
        heap[i] = heap[l];
        i = l;
      end
      heap[i] = heap[hfill + 1];
      return top;
    endfunction

    function void build_tree();
      int unsigned a, b;
      longint unsigned s;
      for (int unsigned k = 1; k < 256; k++) begin
        if (hist[k] != 0 && ntot < NODES) begin
          lft[ntot] = 0; rgt[ntot] = 0; frq[ntot] = hist[k]; sy[ntot] = k[7:0];
          heap_push(ntot);
          ntot++;
        end
      end
      while (hfill >= 2 && ntot < NODES) begin
        a = heap_pop();
        b = heap_pop();
        s = longint'(freq_of(a)) + longint'(freq_of(b));
        lft[ntot] = a; rgt[ntot] = b;
        frq[ntot] = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
        sy[ntot] = 0;
        heap_push(ntot);
        ntot++;
      end
      root = hfill >= 1 ? heap[1] : 0;
      walk = root;
      emitted = 0;
    endfunction

    function void note_input(hbd_pkg::in_t t);
      hbd_pkg::out_t e;
      int unsigned lim, w, nx;
      bit usable;
      e = '0;
      lim = (max_sym == '0) ? 32'd1 : 32'(max_sym);
      usable = ntot >= 3;
      case (t.command)
        hbd_pkg::CMD_CLEAR: clear_all();
        hbd_pkg::CMD_COUNT: begin
          if (ph != PH_COUNT) e.status = hbd_pkg::STAT_PHASE;
          else if (t.value != 0 && hist[t.value] != 32'hFFFF_FFFF) hist[t.value]++;
        end
        hbd_pkg::CMD_BUILD: begin
          if (ph != PH_COUNT) e.status = hbd_pkg::STAT_PHASE;
          else begin
            build_tree();
            ph = PH_DECODE;
          end
        end
        hbd_pkg::CMD_BIT: begin
          if (ph != PH_DECODE) e.status = hbd_pkg::STAT_PHASE;
          else if (!usable) e.status = hbd_pkg::STAT_NOTREE;
          else if (emitted < lim) begin
            w = walk < NODES ? walk : 0;
            nx = t.value == 0 ? lft[w] : rgt[w];
            if (nx >= NODES) nx = 0;
            if (sy[nx] != 0) begin
              e.symbol = sy[nx];
              e.symbol_valid = 1'b1;
              emitted = (emitted + 1) & 32'h1FFFF;
              walk = root;
            end else walk = nx;
          end
        end
        hbd_pkg::CMD_END: begin
          if (ph != PH_DECODE) e.status = hbd_pkg::STAT_PHASE;
          else if (!usable) e.status = hbd_pkg::STAT_NOTREE;
          else begin
            e.status = walk != root ? hbd_pkg::STAT_MIDCODE : hbd_pkg::STAT_OK;
            e.decoded_count = emitted[16:0];
            walk = root;
            emitted = 0;
            pending.push_back(e);
            return;
          end
        end
        default: e.status = hbd_pkg::STAT_PHASE;
      endcase
      e.decoded_count = emitted[16:0];
      pending.push_back(e);
    endfunction

    task check_result(hbd_pkg::out_t r);
      hbd_pkg::out_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no transaction waiting");
        return;
      end
      e = pending.pop_front();
      if (r.symbol !== e.symbol)
        report_mismatch($sformatf("symbol %0h want %0h", r.symbol, e.symbol));
      if (r.symbol_valid !== e.symbol_valid)
        report_mismatch($sformatf("symbol_valid %0b want %0b", r.symbol_valid,
                                  e.symbol_valid));
      if (r.status !== e.status)
        report_mismatch($sformatf("status %0d want %0d", r.status, e.status));
      if (r.decoded_count !== e.decoded_count)
        report_mismatch($sformatf("decoded_count %0d want %0d", r.decoded_count,
                                  e.decoded_count));
    endtask
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  hbd_pkg::in_t  in_pkt = '0;
  logic          done_o;
  hbd_pkg::out_t res_o;
  logic          cfg_we = 1'b0;
  logic [16:0]   cfg_wdata = '0;

  huff_scoreboard sb = new();
  int unsigned idle_pct;
  longint unsigned cycles;
  bit [7:0] alphabet[$];

  huffman_tree_build_and_decode_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_pkt),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  task automatic send(logic [2:0] c, logic [7:0] v);
    hbd_pkg::in_t t;
    t.command = c;
    t.value = v;
    start <= 1'b1;
    in_pkt <= t;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    sb.note_input(t);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [16:0] v);
    drain();
    repeat (10) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.max_sym = v;
  endtask

  // one clear, count, build and decode session with random content
  task automatic session(int unsigned nsym);
    int unsigned n;
    alphabet.delete();
    for (int i = 0; i < nsym; i++) alphabet.push_back(8'($urandom_range(1, 255)));
    send(hbd_pkg::CMD_CLEAR, 8'($urandom));
    n = $urandom_range(nsym, nsym * 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send(3'($urandom_range(0, 7)), 8'($urandom));
      else if ($urandom_range(15) == 0) send(hbd_pkg::CMD_COUNT, 8'd0);
      else send(hbd_pkg::CMD_COUNT, alphabet[$urandom_range(0, nsym - 1)]);
    end
    send(hbd_pkg::CMD_BUILD, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 30)) begin
        if ($urandom_range(29) == 0) send(3'($urandom_range(1, 7)), 8'($urandom));
        else send(hbd_pkg::CMD_BIT, $urandom_range(1) ? 8'd0 : 8'($urandom));
      end
      send(hbd_pkg::CMD_END, 8'($urandom));
    end
  endtask

  initial begin
    idle_pct = 0;
    sb.clear_all();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send(hbd_pkg::CMD_BIT, 8'd0);
    send(hbd_pkg::CMD_END, 8'd0);
    send(3'd5, 8'hFF);
    send(3'd6, 8'd0);
    send(3'd7, 8'h55);
    send(hbd_pkg::CMD_COUNT, 8'd0);
    send(hbd_pkg::CMD_COUNT, 8'hFF);
    send(hbd_pkg::CMD_COUNT, 8'd1);
    send(hbd_pkg::CMD_COUNT, 8'd1);
    send(hbd_pkg::CMD_COUNT, 8'd2);
    send(hbd_pkg::CMD_BUILD, 8'd0);
    send(hbd_pkg::CMD_BUILD, 8'd0);
    send(hbd_pkg::CMD_COUNT, 8'd3);
    send(hbd_pkg::CMD_BIT, 8'd0);
    send(hbd_pkg::CMD_BIT, 8'hFF);
    send(hbd_pkg::CMD_END, 8'd0);
    send(hbd_pkg::CMD_BIT, 8'd1);
    send(hbd_pkg::CMD_END, 8'd0);
    send(hbd_pkg::CMD_CLEAR, 8'd0);
    send(hbd_pkg::CMD_COUNT, 8'd7);
    send(hbd_pkg::CMD_BUILD, 8'd0);
    send(hbd_pkg::CMD_BIT, 8'd0);
    send(hbd_pkg::CMD_END, 8'd0);
    send(hbd_pkg::CMD_CLEAR, 8'hFF);

    write_limit(17'd1);
    session(3);
    write_limit(17'd0);
    session(4);
    write_limit(17'h1FFFF);
    alphabet.delete();
    for (int s = 1; s < 256; s++) send(hbd_pkg::CMD_COUNT, 8'(s));
    send(hbd_pkg::CMD_BUILD, 8'd0);
    repeat (40) send(hbd_pkg::CMD_BIT, 8'($urandom));
    send(hbd_pkg::CMD_END, 8'd0);
    write_limit(17'd65536);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 13;
        default: idle_pct = 0;
      endcase
      for (int k = 0; k < 6; k++) begin
        if (k == 3) drain();
        session($urandom_range(5) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8));
      end
      write_limit(p == 1 ? 17'd3 : 17'($urandom_range(1, 65536)));
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### huffman_tree_build_and_decode_core.f
rtl/core/hbd_pkg.sv
rtl/core/hbd_ctrl.sv
rtl/core/hbd_datapath.sv
rtl/core/huffman_tree_build_and_decode_core.sv
tb/tb.sv
